/* hdl/sid_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse image deframer package
// Shared widths, codes, result types and small helpers for the deframer.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgW       = 40;
  localparam int unsigned DataW      = 64;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned IdxBit     = 3;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic [31:0] SparseMagic   = 32'hED26_FF3A;
  localparam logic [15:0] ChunkRaw      = 16'hCAC1;
  localparam logic [15:0] ChunkDontCare = 16'hCAC3;
  localparam logic [15:0] ChunkCrc32    = 16'hCAC4;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_VERSION    = 2'd1,
    ERR_TOO_LARGE  = 2'd2,
    ERR_CHUNK_TYPE = 2'd3
  } err_e;

  typedef enum logic {
    REG_PARTITION = 1'b0,
    REG_IMAGE     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  write_byte;
    err_e              error_code;
  } res_t;

  typedef struct packed {
    logic [CountW-1:0]         count;
    res_t [MaxResults-1:0]     res;
  } grp_t;

  function automatic res_t mk_write(logic [ByteW-1:0] b);
    res_t r;
    r            = '0;
    r.kind       = KIND_WRITE;
    r.write_byte = b;
    r.error_code = ERR_NONE;
    return r;
  endfunction

  function automatic res_t mk_finish();
    res_t r;
    r            = '0;
    r.kind       = KIND_FINISH;
    r.error_code = ERR_NONE;
    return r;
  endfunction

  function automatic res_t mk_error(err_e code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

/* hdl/sid_if.sv */
// ----------------------------------------------------------------------------
// Sparse image deframer channels
// Valid/ready interfaces for the image byte input and the result output.
// ----------------------------------------------------------------------------
interface sid_in_if;
  import sid_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             image_start;

  modport source (output valid, data_byte, image_start, input ready);
  modport sink   (input valid, data_byte, image_start, output ready);
endinterface

interface sid_out_if #(
  parameter int unsigned OFFSET_BITS = 40
);
  import sid_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [OFFSET_BITS-1:0] disk_offset;
  logic [ByteW-1:0]       write_byte;
  logic [1:0]             error_code;
  logic                   last_of_run;

  modport source (output valid, kind, disk_offset, write_byte, error_code, last_of_run,
                  input ready);
  modport sink   (input valid, kind, disk_offset, write_byte, error_code, last_of_run,
                  output ready);
endinterface

/* hdl/sid_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Sparse image deframer configuration registers
// APB-style register file holding the partition size and plain image length.
// ----------------------------------------------------------------------------
module sid_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sid_pkg::AddrW-1:0]  paddr,
  input  logic [sid_pkg::DataW-1:0]  pwdata,
  output logic [sid_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [sid_pkg::CfgW-1:0]   partition_bytes_o,
  output logic [sid_pkg::CfgW-1:0]   image_bytes_o
);
  import sid_pkg::*;

  reg_idx_e        sel;
  logic            wr_en;
  logic [CfgW-1:0] partition_q;
  logic [CfgW-1:0] image_q;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign sel    = reg_idx_e'(paddr[IdxBit]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partition_q <= '0;
      image_q     <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_PARTITION: partition_q <= pwdata[CfgW-1:0];
        REG_IMAGE:     image_q     <= pwdata[CfgW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PARTITION: prdata = DataW'(partition_q);
      REG_IMAGE:     prdata = DataW'(image_q);
    endcase
  end

  assign partition_bytes_o = partition_q;
  assign image_bytes_o     = image_q;

endmodule

/* hdl/sid_parser.sv */
// ----------------------------------------------------------------------------
// Sparse image deframer parser
// Input register, parse state machine and the result group it produces.
// ----------------------------------------------------------------------------
module sid_parser #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  sid_in_if.sink                                            in_i,
  input  logic [sid_pkg::CfgW-1:0]                          partition_bytes_i,
  input  logic [sid_pkg::CfgW-1:0]                          image_bytes_i,
  input  logic                                              free_i,
  output logic                                              load_o,
  output sid_pkg::grp_t                                     grp_o,
  output logic [sid_pkg::MaxResults-1:0][OFFSET_BITS-1:0]   off_o
);
  import sid_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_SKIP_HDR,
    PH_CHUNK_HDR,
    PH_RAW,
    PH_SKIP_CRC,
    PH_PLAIN,
    PH_PLAIN_FINISH,
    PH_IDLE
  } phase_e;

  localparam int unsigned CntW = 5;
  // Byte positions (before counting) at which header fields complete.
  localparam logic [CntW-1:0] MagicLast      = 5'd3;
  localparam logic [CntW-1:0] HdrVersion     = 5'd5;
  localparam logic [CntW-1:0] HdrFileHdrSize = 5'd9;
  localparam logic [CntW-1:0] HdrBlockSize   = 5'd15;
  localparam logic [CntW-1:0] HdrTotalBlocks = 5'd19;
  localparam logic [CntW-1:0] HdrTotalChunks = 5'd23;
  localparam logic [CntW-1:0] HdrLast        = 5'd27;
  localparam logic [CntW-1:0] ChkType        = 5'd1;
  localparam logic [CntW-1:0] ChkBlocks      = 5'd7;
  localparam logic [CntW-1:0] ChkLast        = 5'd11;
  localparam logic [15:0]     SparseHdrBytes = 16'd28;
  localparam logic [CfgW-1:0] MagicBytes     = CfgW'(MaxResults);

  logic                   vld_q;
  logic [ByteW-1:0]       byte_q;
  logic                   start_q;

  phase_e                 phase_q, phase_d, ph;
  logic [CntW-1:0]        cnt_q, cnt_d, cnt, cnt_inc;
  logic [OFFSET_BITS-1:0] wo_q, wo_d, wo, wo_inc, wo_len;
  logic [31:0]            done_q, done_d, done, done_inc;

  logic [31:0]            shift_q, shift_d, sh_new;
  logic [31:0]            bs_q, bs_d;
  logic [31:0]            total_q, total_d;
  logic [31:0]            blocks_q, blocks_d;
  logic [15:0]            fhs_q, fhs_d;
  logic [15:0]            type_q, type_d;
  logic                   ver_q, ver_d;
  logic [CfgW-1:0]        snap_q, snap_d;
  logic [63:0]            pl_q, pl_d;
  logic [63:0]            prod_q, prod_d;

  logic                   fire;
  logic                   pl_last;
  logic                   cd_finish;
  logic                   too_large;
  grp_t                   grp;
  logic [MaxResults-1:0][OFFSET_BITS-1:0] off;

  assign fire        = vld_q && free_i;
  assign in_i.ready  = !vld_q || fire;
  assign load_o      = fire;
  assign grp_o       = grp;
  assign off_o       = off;

  // A start byte restarts parsing before the byte itself is handled.
  assign ph       = start_q ? PH_MAGIC : phase_q;
  assign cnt      = start_q ? '0 : cnt_q;
  assign wo       = start_q ? '0 : wo_q;
  assign done     = start_q ? '0 : done_q;
  assign sh_new   = {byte_q, (start_q ? 24'd0 : shift_q[31:8])};
  assign cnt_inc  = cnt + CntW'(1);
  assign wo_inc   = wo + OFFSET_BITS'(1);
  assign wo_len   = wo + prod_q[OFFSET_BITS-1:0];
  assign done_inc = done + 32'd1;

  assign pl_last   = (pl_q == 64'd1);
  assign cd_finish = (done_inc >= total_q);
  assign too_large = (prod_q > 64'(snap_q));
  assign prod_d    = 64'(bs_q) * 64'(blocks_q);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    wo_d     = wo_q;
    done_d   = done_q;
    shift_d  = shift_q;
    bs_d     = bs_q;
    total_d  = total_q;
    blocks_d = blocks_q;
    fhs_d    = fhs_q;
    type_d   = type_q;
    ver_d    = ver_q;
    snap_d   = snap_q;
    pl_d     = pl_q;
    grp      = '0;
    off      = '0;

    if (fire) begin
      phase_d = ph;
      cnt_d   = cnt;
      wo_d    = wo;
      done_d  = done;
      shift_d = sh_new;

      unique case (ph)
        PH_MAGIC: begin
          cnt_d = cnt_inc;
          if (cnt == MagicLast) begin
            if (sh_new == SparseMagic) begin
              phase_d = PH_HEADER;
            end else if (image_bytes_i > partition_bytes_i) begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_error(ERR_TOO_LARGE);
              phase_d    = PH_IDLE;
            end else begin
              // Release the buffered bytes that lie inside the image, then
              // close short images in the same group.
              for (int i = 0; i < MaxResults; i++) begin
                if (CfgW'(i) < image_bytes_i) begin
                  grp.res[i] = mk_write(sh_new[ByteW*i +: ByteW]);
                  off[i]     = OFFSET_BITS'(i);
                end else begin
                  grp.res[i] = mk_finish();
                end
              end
              if (image_bytes_i < MagicBytes) begin
                grp.count = CountW'(image_bytes_i[IdxW-1:0]) + CountW'(1);
                phase_d   = PH_IDLE;
              end else if (image_bytes_i == MagicBytes) begin
                grp.count = CountW'(MaxResults);
                phase_d   = PH_PLAIN_FINISH;
              end else begin
                grp.count = CountW'(MaxResults);
                pl_d      = 64'(image_bytes_i) - 64'(MagicBytes);
                wo_d      = OFFSET_BITS'(MaxResults);
                phase_d   = PH_PLAIN;
              end
            end
          end
        end

        PH_HEADER: begin
          cnt_d = cnt_inc;
          case (cnt)
            HdrVersion:     ver_d = (sh_new[31:16] == 16'd1);
            HdrFileHdrSize: fhs_d = sh_new[31:16];
            HdrBlockSize:   bs_d  = sh_new;
            HdrTotalBlocks: begin
              blocks_d = sh_new;
              snap_d   = partition_bytes_i;
            end
            HdrTotalChunks: total_d = sh_new;
            default: ;
          endcase
          if (cnt == HdrLast) begin
            if (!ver_q) begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_error(ERR_VERSION);
              phase_d    = PH_IDLE;
            end else if (too_large) begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_error(ERR_TOO_LARGE);
              phase_d    = PH_IDLE;
            end else if (fhs_q > SparseHdrBytes) begin
              pl_d    = 64'(fhs_q - SparseHdrBytes);
              phase_d = PH_SKIP_HDR;
            end else if (total_q == 32'd0) begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_finish();
              phase_d    = PH_IDLE;
            end else begin
              cnt_d   = '0;
              phase_d = PH_CHUNK_HDR;
            end
          end
        end

        PH_SKIP_HDR: begin
          pl_d = pl_q - 64'd1;
          if (pl_last) begin
            if (total_q == 32'd0) begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_finish();
              phase_d    = PH_IDLE;
            end else begin
              cnt_d   = '0;
              phase_d = PH_CHUNK_HDR;
            end
          end
        end

        PH_CHUNK_HDR: begin
          cnt_d = cnt_inc;
          case (cnt)
            ChkType:   type_d   = sh_new[31:16];
            ChkBlocks: blocks_d = sh_new;
            default: ;
          endcase
          if (cnt == ChkLast) begin
            cnt_d = '0;
            // The chunk length is already registered in prod_q from the block size and count.
            if (type_q == ChunkRaw) begin
              pl_d = prod_q;
              if (prod_q == 64'd0) begin
                done_d = done_inc;
                if (cd_finish) begin
                  grp.count  = CountW'(1);
                  grp.res[0] = mk_finish();
                  phase_d    = PH_IDLE;
                end else begin
                  phase_d = PH_CHUNK_HDR;
                end
              end else begin
                phase_d = PH_RAW;
              end
            end else if (type_q == ChunkDontCare) begin
              wo_d   = wo_len;
              done_d = done_inc;
              if (cd_finish) begin
                grp.count  = CountW'(1);
                grp.res[0] = mk_finish();
                phase_d    = PH_IDLE;
              end else begin
                phase_d = PH_CHUNK_HDR;
              end
            end else if (type_q == ChunkCrc32) begin
              wo_d    = wo_len;
              pl_d    = 64'd4;
              phase_d = PH_SKIP_CRC;
            end else begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_error(ERR_CHUNK_TYPE);
              phase_d    = PH_IDLE;
            end
          end
        end

        PH_RAW: begin
          grp.count  = CountW'(1);
          grp.res[0] = mk_write(byte_q);
          off[0]     = wo;
          wo_d       = wo_inc;
          pl_d       = pl_q - 64'd1;
          if (pl_last) begin
            done_d = done_inc;
            cnt_d  = '0;
            if (cd_finish) begin
              grp.count  = CountW'(2);
              grp.res[1] = mk_finish();
              phase_d    = PH_IDLE;
            end else begin
              phase_d = PH_CHUNK_HDR;
            end
          end
        end

        PH_SKIP_CRC: begin
          pl_d = pl_q - 64'd1;
          if (pl_last) begin
            done_d = done_inc;
            cnt_d  = '0;
            if (cd_finish) begin
              grp.count  = CountW'(1);
              grp.res[0] = mk_finish();
              phase_d    = PH_IDLE;
            end else begin
              phase_d = PH_CHUNK_HDR;
            end
          end
        end

        PH_PLAIN: begin
          grp.count  = CountW'(1);
          grp.res[0] = mk_write(byte_q);
          off[0]     = wo;
          wo_d       = wo_inc;
          pl_d       = pl_q - 64'd1;
          if (pl_last) begin
            grp.count  = CountW'(2);
            grp.res[1] = mk_finish();
            phase_d    = PH_IDLE;
          end
        end

        PH_PLAIN_FINISH: begin
          grp.count  = CountW'(1);
          grp.res[0] = mk_finish();
          phase_d    = PH_IDLE;
        end

        PH_IDLE: ;

        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= PH_MAGIC;
      cnt_q   <= '0;
      wo_q    <= '0;
      done_q  <= '0;
    end else begin
      if (in_i.ready) begin
        vld_q <= in_i.valid;
      end
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      wo_q    <= wo_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.image_start;
    end
    shift_q  <= shift_d;
    bs_q     <= bs_d;
    total_q  <= total_d;
    blocks_q <= blocks_d;
    fhs_q    <= fhs_d;
    type_q   <= type_d;
    ver_q    <= ver_d;
    snap_q   <= snap_d;
    pl_q     <= pl_d;
    prod_q   <= prod_d;
  end

  // Parse state only moves when a buffered byte is actually handled.
  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !free_i) |=> ($stable(phase_q) && $stable(cnt_q) && $stable(wo_q)))
    else $error("parse state changed while the result stage was full");

endmodule

/* hdl/sid_out_stage.sv */
// ----------------------------------------------------------------------------
// Sparse image deframer output stage
// Holds one result group and sends its results one transfer at a time.
// ----------------------------------------------------------------------------
module sid_out_stage #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             load_i,
  input  sid_pkg::grp_t                                    grp_i,
  input  logic [sid_pkg::MaxResults-1:0][OFFSET_BITS-1:0]  off_i,
  output logic                                             free_o,
  sid_out_if.source                                        out_o
);
  import sid_pkg::*;

  logic [CountW-1:0]                      left_q;
  logic [IdxW-1:0]                        idx_q;
  res_t [MaxResults-1:0]                  res_q;
  logic [MaxResults-1:0][OFFSET_BITS-1:0] off_q;
  res_t                                   cur;
  logic                                   fire;
  logic                                   last;

  assign out_o.valid = (left_q != '0);
  assign fire        = out_o.valid && out_o.ready;
  assign last        = (left_q == CountW'(1));
  // The group register frees up in the cycle its last result is taken.
  assign free_o      = (left_q == '0) || (last && out_o.ready);

  assign cur               = res_q[idx_q];
  assign out_o.kind        = cur.kind;
  assign out_o.write_byte  = cur.write_byte;
  assign out_o.error_code  = cur.error_code;
  assign out_o.disk_offset = off_q[idx_q];
  assign out_o.last_of_run = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      idx_q  <= '0;
    end else if (load_i) begin
      left_q <= grp_i.count;
      idx_q  <= '0;
    end else if (fire) begin
      left_q <= left_q - CountW'(1);
      idx_q  <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= grp_i.res;
      off_q <= off_i;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result group loaded over pending results");

  a_group_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (grp_i.count <= CountW'(MaxResults)))
    else $error("result group larger than the group register");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && !load_i) |=> !out_o.valid)
    else $error("output still valid after the last result of a group");

endmodule

/* hdl/sparse_image_deframer_top.sv */
// ----------------------------------------------------------------------------
// Sparse image deframer
// Turns an image byte stream, sparse or plain, into disk write results.
// ----------------------------------------------------------------------------
// Usage:
// Image bytes enter on in_i, one per transfer; image_start marks the first
// byte of an image and restarts parsing. Results leave on out_o, one per
// transfer: a byte write with its disk offset, an image-finished mark, or an
// error with its code. last_of_run flags the final result caused by a byte.
// The partition size and plain image length are written over the APB port
// (8-byte register spacing) while no image traffic is in flight.
// Path: an accepted byte is first held in the input register; once the result
// group register is free, its results are loaded there, and the first can then
// be taken from out_o.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_o does not stall; a byte that yields several results holds the result
// register until all are taken (up to four for the fourth byte of a plain image,
// two when a write also ends the image); there is a single result group register.
// When out_o stalls, the result group holds, the next byte waits in the input
// register and in_i.ready drops only once that register is also occupied.
// Reset is asynchronous: the parser waits for a new image from offset zero,
// both configuration registers clear, and no results are pending.
// ----------------------------------------------------------------------------
module sparse_image_deframer_top #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sid_in_if.sink                     in_i,
  sid_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sid_pkg::AddrW-1:0]  paddr,
  input  logic [sid_pkg::DataW-1:0]  pwdata,
  output logic [sid_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import sid_pkg::*;

  logic [CfgW-1:0]                         partition_bytes;
  logic [CfgW-1:0]                         image_bytes;
  logic                                    grp_free;
  logic                                    grp_load;
  grp_t                                    grp;
  logic [MaxResults-1:0][OFFSET_BITS-1:0]  grp_off;

  // Configuration registers.
  sid_cfg_regs u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .partition_bytes_o (partition_bytes),
    .image_bytes_o     (image_bytes)
  );

  // Input register and parse state machine; each handled byte produces a
  // group of zero to four results in one pass.
  sid_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_i              (in_i),
    .partition_bytes_i (partition_bytes),
    .image_bytes_i     (image_bytes),
    .free_i            (grp_free),
    .load_o            (grp_load),
    .grp_o             (grp),
    .off_o             (grp_off)
  );

  // Result group register that feeds the output channel one transfer at a time.
  sid_out_stage #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (grp_load),
    .grp_i  (grp),
    .off_i  (grp_off),
    .free_o (grp_free),
    .out_o  (out_o)
  );

endmodule

/* test/tb_sparse_image_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse image deframer testbench
// Streams plain and sparse images into the deframer with random gaps and
// output stalls, predicts every disk write, finish mark and error in a model
// of the parser kept here, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_sparse_image_deframer_top;
  import sid_pkg::*;

  localparam int unsigned OffW          = 40;
  localparam int unsigned MaxGap        = 13;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned RandomBytes   = 410;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned SparseHdrBytes = 28;
  localparam int unsigned ChunkHdrBytes  = 12;
  localparam int unsigned CrcBytes       = 4;
  localparam logic [15:0]     MajorVersion = 16'd1;
  localparam logic [15:0]     ChunkFill    = 16'hCAC2;
  localparam logic [CfgW-1:0] CfgMax       = '1;

  typedef enum logic [3:0] {
    ST_MAGIC, ST_HEADER, ST_SKIP_HDR, ST_CHUNK_HDR, ST_RAW, ST_SKIP_CRC,
    ST_PLAIN, ST_PLAIN_DONE, ST_IDLE
  } parse_state_e;

  typedef struct {
    kind_e             kind;
    logic [OffW-1:0]   offset;
    logic [ByteW-1:0]  data;
    err_e              err;
    logic              last;
  } disk_result_t;

  typedef logic [ByteW-1:0] byte_q_t[$];

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  sid_in_if                        in_bus ();
  sid_out_if #(.OFFSET_BITS(OffW)) out_bus ();

  sparse_image_deframer_top #(
    .OFFSET_BITS(OffW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Parser model state and the register copies it reads.
  logic [CfgW-1:0]  partition_q;
  logic [CfgW-1:0]  image_q;
  parse_state_e     pstate;
  logic [31:0]      magic_q;
  logic [15:0]      fcount;
  logic [63:0]      hdr_shift;
  logic [31:0]      bsize;
  logic [15:0]      fhdr_size;
  logic [31:0]      chunks_total;
  logic [31:0]      chunks_done;
  logic [15:0]      ctype;
  logic [63:0]      bytes_left;
  logic [OffW-1:0]  wr_offset;
  logic [31:0]      cblocks;
  logic             version_ok;
  logic             too_large;

  disk_result_t expected_results[$];
  disk_result_t step_batch[MaxResults];
  int           step_count;

  int unsigned bytes_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_off_req = 0;
  bit          no_idle      = 1'b0;

  function automatic void clear_parser();
    pstate       = ST_MAGIC;
    magic_q      = '0;
    fcount       = '0;
    hdr_shift    = '0;
    bsize        = '0;
    fhdr_size    = '0;
    chunks_total = '0;
    chunks_done  = '0;
    ctype        = '0;
    bytes_left   = '0;
    wr_offset    = '0;
    cblocks      = '0;
    version_ok   = 1'b0;
    too_large    = 1'b0;
  endfunction

  function automatic void note_result(kind_e k, logic [OffW-1:0] off, logic [ByteW-1:0] b,
                                      err_e e);
    step_batch[step_count] = '{kind: k, offset: off, data: b, err: e, last: 1'b0};
    step_count++;
  endfunction

  function automatic void raise_error(err_e e);
    note_result(KIND_ERROR, '0, '0, e);
    pstate = ST_IDLE;
  endfunction

  function automatic void mark_finished();
    note_result(KIND_FINISH, '0, '0, ERR_NONE);
    pstate = ST_IDLE;
  endfunction

  function automatic void start_chunks();
    if (chunks_total == '0) begin
      mark_finished();
    end else begin
      pstate = ST_CHUNK_HDR;
      fcount = '0;
    end
  endfunction

  function automatic void close_chunk();
    chunks_done++;
    if (chunks_done >= chunks_total) begin
      mark_finished();
    end else begin
      pstate = ST_CHUNK_HDR;
      fcount = '0;
    end
  endfunction

  function automatic void parse_magic(logic [ByteW-1:0] b);
    magic_q = {b, magic_q[31:8]};
    fcount++;
    if (fcount < 16'd4) return;
    if (magic_q == SparseMagic) begin
      pstate = ST_HEADER;
      return;
    end
    if (image_q > partition_q) begin
      raise_error(ERR_TOO_LARGE);
      return;
    end
    for (int i = 0; i < 4; i++) begin
      if (CfgW'(i) < image_q) note_result(KIND_WRITE, OffW'(i), magic_q[8*i +: 8], ERR_NONE);
    end
    if (image_q < CfgW'(4)) begin
      mark_finished();
    end else if (image_q == CfgW'(4)) begin
      // The finish mark waits for the next byte: four writes fill this step.
      pstate = ST_PLAIN_DONE;
    end else begin
      bytes_left = 64'(image_q) - 64'd4;
      wr_offset  = OffW'(4);
      pstate     = ST_PLAIN;
    end
  endfunction

  function automatic void parse_header(logic [ByteW-1:0] b);
    hdr_shift = {b, hdr_shift[63:8]};
    case (fcount)
      16'd5:  version_ok = (hdr_shift[63:48] == MajorVersion);
      16'd9:  fhdr_size  = hdr_shift[63:48];
      16'd15: bsize      = hdr_shift[63:32];
      16'd19: too_large  = (64'(bsize) * 64'(hdr_shift[63:32])) > 64'(partition_q);
      16'd23: chunks_total = hdr_shift[63:32];
      default: ;
    endcase
    fcount++;
    if (fcount < 16'(SparseHdrBytes)) return;
    if (!version_ok) begin
      raise_error(ERR_VERSION);
    end else if (too_large) begin
      raise_error(ERR_TOO_LARGE);
    end else if (fhdr_size > 16'(SparseHdrBytes)) begin
      bytes_left = 64'(fhdr_size) - 64'(SparseHdrBytes);
      pstate     = ST_SKIP_HDR;
    end else begin
      start_chunks();
    end
  endfunction

  function automatic void parse_chunk_header(logic [ByteW-1:0] b);
    logic [63:0] len;
    hdr_shift = {b, hdr_shift[63:8]};
    if (fcount == 16'd1) ctype = hdr_shift[63:48];
    else if (fcount == 16'd7) cblocks = hdr_shift[63:32];
    fcount++;
    if (fcount < 16'(ChunkHdrBytes)) return;
    fcount = '0;
    len    = 64'(bsize) * 64'(cblocks);
    if (ctype == ChunkRaw) begin
      bytes_left = len;
      if (len == '0) close_chunk();
      else pstate = ST_RAW;
    end else if (ctype == ChunkDontCare) begin
      wr_offset = wr_offset + len[OffW-1:0];
      close_chunk();
    end else if (ctype == ChunkCrc32) begin
      wr_offset  = wr_offset + len[OffW-1:0];
      bytes_left = 64'(CrcBytes);
      pstate     = ST_SKIP_CRC;
    end else begin
      raise_error(ERR_CHUNK_TYPE);
    end
  endfunction

  // Works out the results that one accepted byte causes and queues them.
  function automatic void predict_byte(logic [ByteW-1:0] b, logic start);
    step_count = 0;
    if (start) clear_parser();
    case (pstate)
      ST_MAGIC:     parse_magic(b);
      ST_HEADER:    parse_header(b);
      ST_SKIP_HDR: begin
        bytes_left--;
        if (bytes_left == '0) start_chunks();
      end
      ST_CHUNK_HDR: parse_chunk_header(b);
      ST_RAW: begin
        note_result(KIND_WRITE, wr_offset, b, ERR_NONE);
        wr_offset++;
        bytes_left--;
        if (bytes_left == '0) close_chunk();
      end
      ST_SKIP_CRC: begin
        bytes_left--;
        if (bytes_left == '0) close_chunk();
      end
      ST_PLAIN: begin
        note_result(KIND_WRITE, wr_offset, b, ERR_NONE);
        wr_offset++;
        bytes_left--;
        if (bytes_left == '0) mark_finished();
      end
      ST_PLAIN_DONE: mark_finished();
      default:       pstate = ST_IDLE;
    endcase
    for (int i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_batch[i].last = 1'b1;
      expected_results.push_back(step_batch[i]);
    end
  endfunction

  // One byte transfer on the input channel, after a random gap.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic start);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= b;
    in_bus.image_start <= start;
    do @(posedge clk_i); while (!in_bus.ready);
    bytes_sent++;
    predict_byte(b, start);
  endtask

  task automatic send_image(ref byte_q_t img);
    foreach (img[i]) send_byte(img[i], i == 0);
  endtask

  // Stops offering bytes until every predicted result has been taken, then
  // lets the pipeline run dry for bytes that cause no result.
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input reg_idx_e idx, input logic [CfgW-1:0] value);
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    settle_block();
    addr             = AddrW'(idx) << IdxBit;
    data             = {$urandom, $urandom};
    data[CfgW-1:0]   = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_PARTITION) partition_q = value;
    else image_q = value;
  endtask

  function automatic void put_le(ref byte_q_t img, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(ref byte_q_t img, input int n);
    repeat (n) img.push_back(ByteW'($urandom));
  endfunction

  function automatic void add_sparse_header(ref byte_q_t img, input logic [15:0] major,
                                            input logic [15:0] fhs, input logic [31:0] bs,
                                            input logic [31:0] blks, input logic [31:0] nch);
    put_le(img, 64'(SparseMagic), 4);
    put_le(img, 64'(major), 2);
    put_le(img, 64'($urandom), 2);
    put_le(img, 64'(fhs), 2);
    put_le(img, 64'($urandom), 2);
    put_le(img, 64'(bs), 4);
    put_le(img, 64'(blks), 4);
    put_le(img, 64'(nch), 4);
    put_le(img, 64'($urandom), 4);
    if (fhs > 16'(SparseHdrBytes)) put_random(img, int'(fhs) - SparseHdrBytes);
  endfunction

  function automatic void add_chunk(ref byte_q_t img, input logic [15:0] kind,
                                    input logic [31:0] cs, input int payload);
    put_le(img, 64'(kind), 2);
    put_le(img, 64'($urandom), 2);
    put_le(img, 64'(cs), 4);
    put_le(img, 64'($urandom), 4);
    put_random(img, payload);
  endfunction

  // Raw payloads stay at a dozen bytes or less; skipped chunks may be huge.
  function automatic void add_random_chunk(ref byte_q_t img, input logic [31:0] bs);
    int unsigned pick;
    logic [31:0] cs;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      if (bs == '0) cs = $urandom;
      else if (bs <= 32'd4) cs = $urandom_range(0, 12 / int'(bs));
      else cs = '0;
      add_chunk(img, ChunkRaw, cs, int'(bs * cs));
    end else begin
      cs = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 5));
      if (pick < 6) add_chunk(img, ChunkDontCare, cs, 0);
      else if (pick < 8) add_chunk(img, ChunkCrc32, cs, CrcBytes);
      else if (pick == 8) add_chunk(img, ChunkFill, cs, $urandom_range(0, 3));
      else add_chunk(img, 16'($urandom), cs, $urandom_range(0, 3));
    end
  endfunction

  // Mostly well-formed sparse images with random content; the rest are plain
  // images, bad versions, oversize headers, odd chunk counts and cut streams.
  function automatic void make_random_image(ref byte_q_t img);
    int unsigned pick;
    int unsigned nch;
    int unsigned listed;
    int unsigned cut;
    logic [15:0] major;
    logic [15:0] fhs;
    logic [31:0] bs;
    logic [31:0] blks;
    img.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      put_random(img, $urandom_range(1, 12));
      return;
    end
    major = MajorVersion;
    if (pick < 18) begin
      do major = 16'($urandom); while (major == MajorVersion);
    end
    case ($urandom_range(0, 9))
      0:       bs = '0;
      8:       bs = '1;
      9:       bs = 32'h0001_0000;
      default: bs = $urandom_range(1, 4);
    endcase
    blks = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 16));
    // Sixty-four kilobyte blocks times as many blocks only overflows 32 bits.
    if (bs == 32'h0001_0000 && $urandom_range(0, 1)) blks = 32'h0001_0000;
    pick = $urandom_range(0, 99);
    if (pick < 70) fhs = 16'(SparseHdrBytes);
    else if (pick < 85) fhs = 16'($urandom_range(0, SparseHdrBytes - 1));
    else fhs = 16'($urandom_range(SparseHdrBytes + 1, SparseHdrBytes + 6));
    nch    = $urandom_range(0, 4);
    listed = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : nch;
    add_sparse_header(img, major, fhs, bs, blks, 32'(nch));
    repeat (listed) add_random_chunk(img, bs);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, img.size());
      while (img.size() > cut) void'(img.pop_back());
    end
  endfunction

  task automatic run_random_images(input int unsigned nbytes);
    byte_q_t     img;
    int unsigned target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      make_random_image(img);
      send_image(img);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic test_plain_directed();
    byte_q_t img;
    // Zero-length plain image: only the finish mark, then a byte that is ignored.
    set_register(REG_PARTITION, '0);
    set_register(REG_IMAGE, '0);
    img = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A};
    send_image(img);
    // Plain image longer than the partition fails on its fourth byte.
    set_register(REG_IMAGE, CfgW'(1));
    img = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_image(img);
    // Exactly four bytes, one bit off the magic: the finish mark comes a byte late.
    set_register(REG_PARTITION, CfgMax);
    set_register(REG_IMAGE, CfgW'(4));
    img = '{8'h3A, 8'hFF, 8'h26, 8'hEC, 8'h11};
    send_image(img);
    // Three bytes: writes and the finish mark leave together.
    set_register(REG_IMAGE, CfgW'(3));
    img = '{8'h01, 8'h80, 8'h7F, 8'hFE};
    send_image(img);
    // Longest plain length, cut off by the next image.
    set_register(REG_IMAGE, CfgMax);
    img = '{8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h96};
    send_image(img);
  endtask

  task automatic test_random_full_partition();
    set_register(REG_PARTITION, CfgMax);
    set_register(REG_IMAGE, CfgW'($urandom_range(0, 12)));
    run_random_images(30);
  endtask

  // Two skipped chunks of 255-byte blocks bring the offset to its top value;
  // the raw chunk then writes across the wrap before a restart cuts it off.
  task automatic test_offset_wrap();
    byte_q_t img;
    set_register(REG_PARTITION, CfgMax);
    add_sparse_header(img, MajorVersion, 16'(SparseHdrBytes), 32'd255, 32'd0, 32'd3);
    add_chunk(img, ChunkDontCare, 32'hFFFF_FFFF, 0);
    add_chunk(img, ChunkDontCare, 32'd16843010, 0);
    add_chunk(img, ChunkRaw, 32'd1, 4);
    send_image(img);
  endtask

  task automatic test_back_pressure();
    byte_q_t img;
    set_register(REG_IMAGE, CfgW'($urandom_range(0, 12)));
    add_sparse_header(img, MajorVersion, 16'(SparseHdrBytes), 32'd4, 32'd16, 32'd4);
    repeat (4) add_chunk(img, ChunkRaw, 32'd3, 12);
    hold_off_req = HoldOffCycles;
    send_image(img);
    // The sender waits here until every write has drained before going on.
    settle_block();
    run_random_images(15);
  endtask

  task automatic test_no_idle();
    set_register(REG_PARTITION, CfgW'($urandom_range(0, 80)));
    set_register(REG_IMAGE, CfgW'($urandom_range(0, 8)));
    no_idle = 1'b1;
    run_random_images(30);
    no_idle = 1'b0;
  endtask

  task automatic test_empty_partition();
    set_register(REG_PARTITION, '0);
    set_register(REG_IMAGE, '0);
    run_random_images(25);
  endtask

  task automatic test_random_config();
    int unsigned goal;
    set_register(REG_PARTITION, CfgW'({$urandom, $urandom}));
    set_register(REG_IMAGE, CfgW'($urandom_range(0, 16)));
    goal = RandomBytes;
    if (bytes_sent + 16 < goal) run_random_images(goal - bytes_sent);
    else run_random_images(16);
  endtask

  // Result side: a random stall before each transfer, plus one long hold-off.
  initial begin
    int unsigned n;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req > 0) begin
        n            = hold_off_req;
        hold_off_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, MaxGap);
      end
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  always @(posedge clk_i) begin : result_check
    disk_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result: kind %0d offset %h byte %h err %0d last %0b",
                   out_bus.kind, out_bus.disk_offset, out_bus.write_byte,
                   out_bus.error_code, out_bus.last_of_run);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_bus.kind !== want.kind || out_bus.disk_offset !== want.offset ||
            out_bus.write_byte !== want.data || out_bus.error_code !== want.err ||
            out_bus.last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("mismatch: expected kind %0d offset %h byte %h err %0d last %0b",
                     want.kind, want.offset, want.data, want.err, want.last);
            $display("          actual   kind %0d offset %h byte %h err %0d last %0b",
                     out_bus.kind, out_bus.disk_offset, out_bus.write_byte,
                     out_bus.error_code, out_bus.last_of_run);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("** sparse_image_deframer_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.data_byte   <= '0;
    in_bus.image_start <= 1'b0;
    partition_q = '0;
    image_q     = '0;
    clear_parser();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_directed();
    test_random_full_partition();
    test_offset_wrap();
    test_back_pressure();
    test_no_idle();
    test_empty_partition();
    test_random_config();

    settle_block();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** sparse_image_deframer_top: PASSED **");
    end else begin
      $display("** sparse_image_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sparse_image_deframer_top.f */
hdl/sid_pkg.sv
hdl/sid_if.sv
hdl/sid_cfg_regs.sv
hdl/sid_parser.sv
hdl/sid_out_stage.sv
hdl/sparse_image_deframer_top.sv
test/tb_sparse_image_deframer_top.sv
